// ===== hw/rtl/condition_code_unit_macros.svh =====
// Assertion macros for the condition code unit RTL.
`ifndef CONDITION_CODE_UNIT_MACROS_SVH
`define CONDITION_CODE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ccu_pkg.sv =====
// Types and codes shared by the condition code unit modules.
`timescale 1ns / 1ps
`default_nettype none

package ccu_pkg;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_TEST   = 1'b1
  } ccu_cmd_e;

  // Flag register layout: bit4 X, bit3 N, bit2 Z, bit1 V, bit0 C.
  typedef struct packed {
    logic x;
    logic n;
    logic z;
    logic v;
    logic c;
  } ccu_flags_t;

  typedef struct packed {
    logic        x_rule;
    logic [1:0]  n_rule;
    logic [1:0]  z_rule;
    logic [2:0]  v_rule;
    logic [3:0]  c_rule;
    logic [1:0]  size_code;
    logic [5:0]  shift_count;
    logic [31:0] source_operand;
    logic [31:0] dest_operand;
    logic [31:0] result_value;
  } ccu_upd_t;

  localparam logic X_KEEP = 1'b0;
  localparam logic X_COPY = 1'b1;

  localparam logic [1:0] N_KEEP   = 2'd0;
  localparam logic [1:0] N_CLEAR  = 2'd1;
  localparam logic [1:0] N_SIGN   = 2'd2;
  localparam logic [1:0] N_TOGGLE = 2'd3;

  localparam logic [1:0] Z_KEEP   = 2'd0;
  localparam logic [1:0] Z_TOGGLE = 2'd1;
  localparam logic [1:0] Z_ZERO   = 2'd2;
  localparam logic [1:0] Z_STICKY = 2'd3;

  localparam logic [2:0] V_KEEP   = 3'd0;
  localparam logic [2:0] V_CLEAR  = 3'd1;
  localparam logic [2:0] V_TOGGLE = 3'd2;
  localparam logic [2:0] V_ADD    = 3'd3;
  localparam logic [2:0] V_SUB    = 3'd4;
  localparam logic [2:0] V_DR     = 3'd5;
  localparam logic [2:0] V_ASL    = 3'd6;

  localparam logic [3:0] C_KEEP   = 4'd0;
  localparam logic [3:0] C_TOGGLE = 4'd1;
  localparam logic [3:0] C_CLEAR  = 4'd2;
  localparam logic [3:0] C_FROM_X = 4'd3;
  localparam logic [3:0] C_ROR    = 4'd4;
  localparam logic [3:0] C_ROL    = 4'd5;
  localparam logic [3:0] C_DR     = 4'd6;
  localparam logic [3:0] C_ADD    = 4'd7;
  localparam logic [3:0] C_SUB    = 4'd8;
  localparam logic [3:0] C_ASR    = 4'd9;
  localparam logic [3:0] C_LSR    = 4'd10;
  localparam logic [3:0] C_LSL    = 4'd11;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  localparam logic [3:0] COND_T  = 4'd0;
  localparam logic [3:0] COND_F  = 4'd1;
  localparam logic [3:0] COND_HI = 4'd2;
  localparam logic [3:0] COND_LS = 4'd3;
  localparam logic [3:0] COND_CC = 4'd4;
  localparam logic [3:0] COND_CS = 4'd5;
  localparam logic [3:0] COND_NE = 4'd6;
  localparam logic [3:0] COND_EQ = 4'd7;
  localparam logic [3:0] COND_VC = 4'd8;
  localparam logic [3:0] COND_VS = 4'd9;
  localparam logic [3:0] COND_PL = 4'd10;
  localparam logic [3:0] COND_MI = 4'd11;
  localparam logic [3:0] COND_GE = 4'd12;
  localparam logic [3:0] COND_LT = 4'd13;
  localparam logic [3:0] COND_GT = 4'd14;
  localparam logic [3:0] COND_LE = 4'd15;

endpackage

`default_nettype wire

// ===== hw/rtl/condition_code_unit.sv =====
// Top level of the condition code unit: input stage, flag register, result stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per instruction:
//   command_i selects an update of the X N Z V C flags by per-flag rule codes,
//   or a test of one of the sixteen branch conditions on the current flags.
//   Output channel (out_valid_o / out_stall_i) returns exactly one beat per
//   input beat: the flags after that beat and, for tests, the condition outcome
//   (0 for updates).
//   A beat passes the input register, then the result register, before
//   out_valid_o rises. Throughput: one beat per cycle while the output is not
//   stalled; the flag logic between the two registers is a single pass over five
//   flag bits and its carry mux.
//   Reset: all flags clear, both stages empty.
//   A stall on the output holds the result beat; the input stage still takes one
//   more beat and then stalls the input until the result moves on.
`timescale 1ns / 1ps
`default_nettype none
`include "condition_code_unit_macros.svh"

module condition_code_unit
  import ccu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic        x_rule_i,
  input  logic [1:0]  n_rule_i,
  input  logic [1:0]  z_rule_i,
  input  logic [2:0]  v_rule_i,
  input  logic [3:0]  c_rule_i,
  input  logic [1:0]  size_code_i,
  input  logic [5:0]  shift_count_i,
  input  logic [31:0] source_operand_i,
  input  logic [31:0] dest_operand_i,
  input  logic [31:0] result_value_i,
  input  logic [3:0]  condition_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  flags_o,
  output logic        condition_true_o
);

  logic       in_accept;
  logic       advance;
  logic       s1_valid_q;
  logic       s1_valid_d;
  ccu_cmd_e   s1_cmd_q;
  logic [3:0] s1_cond_q;
  ccu_upd_t   s1_upd_q;
  ccu_flags_t flags_q;
  ccu_flags_t flags_d;
  ccu_flags_t upd_flags;
  logic       cond_true;
  logic       out_valid_q;
  logic       out_valid_d;
  ccu_flags_t out_flags_q;
  logic       out_true_q;

  // Result stage frees up when empty or when its beat is taken this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  ccu_flag_eval u_flag_eval (
    .flags_i (flags_q),
    .upd_i   (s1_upd_q),
    .flags_o (upd_flags)
  );

  ccu_cond_eval u_cond_eval (
    .flags_i     (flags_q),
    .condition_i (s1_cond_q),
    .cond_true_o (cond_true)
  );

  // Tests leave the flags alone.
  assign flags_d = (s1_cmd_q == CMD_TEST) ? flags_q : upd_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q                <= ccu_cmd_e'(command_i);
      s1_cond_q               <= condition_i;
      s1_upd_q.x_rule         <= x_rule_i;
      s1_upd_q.n_rule         <= n_rule_i;
      s1_upd_q.z_rule         <= z_rule_i;
      s1_upd_q.v_rule         <= v_rule_i;
      s1_upd_q.c_rule         <= c_rule_i;
      s1_upd_q.size_code      <= size_code_i;
      s1_upd_q.shift_count    <= shift_count_i;
      s1_upd_q.source_operand <= source_operand_i;
      s1_upd_q.dest_operand   <= dest_operand_i;
      s1_upd_q.result_value   <= result_value_i;
    end
    if (advance) begin
      out_flags_q <= flags_d;
      out_true_q  <= (s1_cmd_q == CMD_TEST) ? cond_true : 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flags_o          = out_flags_q;
  assign condition_true_o = out_true_q;

  `CCU_ASSERT_NEXT(a_test_keeps_flags, clk_i, rst_ni,
    advance && (s1_cmd_q == CMD_TEST), flags_q == $past(flags_q),
    "test beat changed the flag register")

  `CCU_ASSERT_NEXT(a_update_not_true, clk_i, rst_ni,
    advance && (s1_cmd_q == CMD_UPDATE), !condition_true_o,
    "update beat reported a true condition")

  `CCU_ASSERT_NOW(a_out_matches_state, clk_i, rst_ni,
    out_valid_q, out_flags_q == flags_q,
    "pending result flags differ from the flag register")

  `CCU_ASSERT_NOW(a_empty_out_no_stall, clk_i, rst_ni,
    !out_valid_q, !in_stall_o,
    "input stalled while the result stage is empty")

endmodule

`default_nettype wire

// ===== hw/rtl/ccu_flag_eval.sv =====
// Next-flag logic for an update beat: N, Z, V, C rules and the X copy.
`timescale 1ns / 1ps
`default_nettype none

module ccu_flag_eval
  import ccu_pkg::*;
(
  input  ccu_flags_t flags_i,
  input  ccu_upd_t   upd_i,
  output ccu_flags_t flags_o
);

  function automatic logic bit_at(input logic [31:0] val, input logic [5:0] pos);
    bit_at = pos[5] ? 1'b0 : val[pos[4:0]];
  endfunction

  logic [5:0]  size_w;
  logic [5:0]  size_m1;
  logic [31:0] mask;
  logic [31:0] sign_bit;
  logic [31:0] src_m;
  logic [31:0] dst_m;
  logic [31:0] res_m;
  logic        sm;
  logic        dm;
  logic        rm;
  logic        res_zero;
  logic [5:0]  cnt;
  logic [31:0] asl_top;
  logic        asl_v;
  logic [5:0]  ror_k;
  logic [5:0]  rol_k;
  logic [5:0]  asr_k;
  logic        cnt_big;
  logic        cnt_zero;
  ccu_flags_t  nf;

  always_comb begin
    case (upd_i.size_code)
      SIZE_BYTE: begin
        size_w = 6'd8;
        mask   = 32'h0000_00ff;
      end
      SIZE_WORD: begin
        size_w = 6'd16;
        mask   = 32'h0000_ffff;
      end
      default: begin
        size_w = 6'd32;
        mask   = 32'hffff_ffff;
      end
    endcase
  end

  assign size_m1  = size_w - 6'd1;
  assign sign_bit = mask & ~(mask >> 1);
  assign src_m    = upd_i.source_operand & mask;
  assign dst_m    = upd_i.dest_operand & mask;
  assign res_m    = upd_i.result_value & mask;
  assign sm       = |(src_m & sign_bit);
  assign dm       = |(dst_m & sign_bit);
  assign rm       = |(res_m & sign_bit);
  assign res_zero = (res_m == 32'd0);
  assign cnt      = upd_i.shift_count;
  assign cnt_big  = (cnt > size_w);
  assign cnt_zero = (cnt == 6'd0);

  // ASL overflow: top count+1 bits of the source must all agree.
  assign asl_top = ~(mask >> ({1'b0, cnt} + 7'd1)) & mask;
  assign asl_v   = (cnt >= size_w) ? (src_m != 32'd0)
                                   : ((|(asl_top & src_m)) && (|(asl_top & ~src_m)));

  // Rotate and arithmetic shift counts, reduced or clamped to the size.
  always_comb begin
    ror_k = cnt_big ? (cnt & size_m1) : cnt;
    if (ror_k == 6'd0) begin
      ror_k = size_w;
    end
  end
  assign rol_k = cnt & size_m1;
  assign asr_k = cnt_big ? size_w : cnt;

  always_comb begin
    nf = flags_i;

    case (upd_i.n_rule)
      N_KEEP:   nf.n = flags_i.n;
      N_CLEAR:  nf.n = 1'b0;
      N_SIGN:   nf.n = rm;
      N_TOGGLE: nf.n = ~flags_i.n;
      default:  nf.n = flags_i.n;
    endcase

    case (upd_i.z_rule)
      Z_KEEP:   nf.z = flags_i.z;
      Z_TOGGLE: nf.z = ~flags_i.z;
      Z_ZERO:   nf.z = res_zero;
      Z_STICKY: nf.z = flags_i.z & res_zero;
      default:  nf.z = flags_i.z;
    endcase

    case (upd_i.v_rule)
      V_KEEP:   nf.v = flags_i.v;
      V_CLEAR:  nf.v = 1'b0;
      V_TOGGLE: nf.v = ~flags_i.v;
      V_ADD:    nf.v = (sm & dm & ~rm) | (~sm & ~dm & rm);
      V_SUB:    nf.v = (~sm & dm & ~rm) | (sm & ~dm & rm);
      V_DR:     nf.v = dm & rm;
      V_ASL:    nf.v = asl_v;
      default:  nf.v = flags_i.v;
    endcase

    case (upd_i.c_rule)
      C_KEEP:   nf.c = flags_i.c;
      C_TOGGLE: nf.c = ~flags_i.c;
      C_CLEAR:  nf.c = 1'b0;
      C_FROM_X: nf.c = flags_i.x;
      C_ROR:    nf.c = bit_at(dst_m, ror_k - 6'd1);
      C_ROL:    nf.c = (rol_k == 6'd0) ? dst_m[0] : bit_at(dst_m, size_w - rol_k);
      C_DR:     nf.c = dm | rm;
      C_ADD:    nf.c = (sm & dm) | (~rm & dm) | (sm & ~rm);
      C_SUB:    nf.c = (sm & ~dm) | (rm & ~dm) | (sm & rm);
      C_ASR:    nf.c = (asr_k == 6'd0) ? 1'b0 : bit_at(dst_m, asr_k - 6'd1);
      C_LSR:    nf.c = (cnt_big || cnt_zero) ? 1'b0 : bit_at(dst_m, cnt - 6'd1);
      C_LSL:    nf.c = (cnt_big || cnt_zero) ? 1'b0 : bit_at(dst_m, size_w - cnt);
      default:  nf.c = flags_i.c;
    endcase

    // With X_COPY, X follows the new carry last; X_KEEP holds it.
    case (upd_i.x_rule)
      X_COPY:  nf.x = nf.c;
      X_KEEP:  nf.x = flags_i.x;
      default: nf.x = flags_i.x;
    endcase
  end

  assign flags_o = nf;

endmodule

`default_nettype wire

// ===== hw/rtl/ccu_cond_eval.sv =====
// Branch condition evaluation on the current flags.
`timescale 1ns / 1ps
`default_nettype none

module ccu_cond_eval
  import ccu_pkg::*;
(
  input  ccu_flags_t  flags_i,
  input  logic [3:0]  condition_i,
  output logic        cond_true_o
);

  always_comb begin
    case (condition_i)
      COND_T:  cond_true_o = 1'b1;
      COND_F:  cond_true_o = 1'b0;
      COND_HI: cond_true_o = ~flags_i.c & ~flags_i.z;
      COND_LS: cond_true_o = flags_i.c | flags_i.z;
      COND_CC: cond_true_o = ~flags_i.c;
      COND_CS: cond_true_o = flags_i.c;
      COND_NE: cond_true_o = ~flags_i.z;
      COND_EQ: cond_true_o = flags_i.z;
      COND_VC: cond_true_o = ~flags_i.v;
      COND_VS: cond_true_o = flags_i.v;
      COND_PL: cond_true_o = ~flags_i.n;
      COND_MI: cond_true_o = flags_i.n;
      COND_GE: cond_true_o = ~(flags_i.n ^ flags_i.v);
      COND_LT: cond_true_o = flags_i.n ^ flags_i.v;
      COND_GT: cond_true_o = ~(flags_i.n ^ flags_i.v) & ~flags_i.z;
      COND_LE: cond_true_o = (flags_i.n ^ flags_i.v) | flags_i.z;
      default: cond_true_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
